[design/multiply_divide_unit_core_defines.svh]
// ----------------------------------------------------------------------------
// Multiply/divide unit assertion macros
// Shared assertion shorthands for the checker of the HI/LO unit.
// ----------------------------------------------------------------------------
`ifndef MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH
`define MULTIPLY_DIVIDE_UNIT_CORE_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define MDU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define MDU_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[design/mdu_pkg.sv]
// ----------------------------------------------------------------------------
// Multiply/divide unit package
// Shared widths, command codes and control types of the HI/LO unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdu_pkg;

    localparam int DATA_W     = 32;
    localparam int CMD_W      = 3;
    localparam int ITERATIONS = DATA_W;
    localparam int CNT_W      = $clog2(ITERATIONS);

    // Command codes carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_MULT    = 3'd0,
        CMD_MULTU   = 3'd1,
        CMD_DIV     = 3'd2,
        CMD_DIVU    = 3'd3,
        CMD_WRITE_HI = 3'd4,
        CMD_WRITE_LO = 3'd5,
        CMD_READ_HI  = 3'd6,
        CMD_READ_LO  = 3'd7
    } mdu_cmd_t;

    // Operation selection handed to the arithmetic unit.
    typedef struct packed {
        logic is_div;
        logic is_signed;
    } mdu_op_t;

endpackage

[design/mdu_alu.sv]
// ----------------------------------------------------------------------------
// Multiply/divide arithmetic unit
// Shift-add multiplier and restoring divider sharing one 34-bit adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdu_alu (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  mdu_pkg::mdu_op_t           op,
    input  logic [mdu_pkg::DATA_W-1:0] operand_a,
    input  logic [mdu_pkg::DATA_W-1:0] operand_b,
    output logic                       done,
    output logic [mdu_pkg::DATA_W-1:0] hi_out,
    output logic [mdu_pkg::DATA_W-1:0] lo_out
);
    import mdu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX
    } alu_state_t;

    alu_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [2*DATA_W-1:0]     work_reg, work_next;
    logic [DATA_W-1:0]       opnd_reg, opnd_next;
    logic                    is_div_reg, is_div_next;
    logic                    neg_q_reg, neg_q_next;
    logic                    neg_r_reg, neg_r_next;

    logic                    neg_a, neg_b;
    logic [DATA_W-1:0]       mag_a, mag_b;
    logic [DATA_W:0]         rem_shift;
    logic [DATA_W:0]         add_x;
    logic [DATA_W+1:0]       add_y;
    logic [DATA_W+1:0]       add_sum;
    logic [2*DATA_W-1:0]     step_work;
    logic [2*DATA_W-1:0]     prod_fixed;
    logic [DATA_W-1:0]       quot_fixed, rem_fixed;

    // Operand magnitudes and sign flags taken at start.
    always_comb begin
        neg_a = op.is_signed & operand_a[DATA_W-1];
        neg_b = op.is_signed & operand_b[DATA_W-1];
        mag_a = neg_a ? (~operand_a + 1'b1) : operand_a;
        mag_b = neg_b ? (~operand_b + 1'b1) : operand_b;
    end

    // Shared adder: adds the multiplicand, or subtracts the divisor as a trial.
    always_comb begin
        rem_shift = {work_reg[2*DATA_W-1:DATA_W], work_reg[DATA_W-1]};
        if (is_div_reg) begin
            add_x = rem_shift;
            add_y = ~{2'b00, opnd_reg};
        end else begin
            add_x = {1'b0, work_reg[2*DATA_W-1:DATA_W]};
            add_y = work_reg[0] ? {2'b00, opnd_reg} : '0;
        end
        add_sum = {1'b0, add_x} + add_y + {{(DATA_W+1){1'b0}}, is_div_reg};
    end

    // One multiply or divide iteration.
    always_comb begin
        if (is_div_reg) begin
            if (!add_sum[DATA_W+1]) begin
                step_work = {add_sum[DATA_W-1:0], work_reg[DATA_W-2:0], 1'b1};
            end else begin
                step_work = {rem_shift[DATA_W-1:0], work_reg[DATA_W-2:0], 1'b0};
            end
        end else begin
            step_work = {add_sum[DATA_W:0], work_reg[DATA_W-1:1]};
        end
    end

    // Sign correction of the finished magnitudes.
    always_comb begin
        prod_fixed = neg_q_reg ? (~work_reg + 1'b1) : work_reg;
        quot_fixed = neg_q_reg ? (~work_reg[DATA_W-1:0] + 1'b1) : work_reg[DATA_W-1:0];
        rem_fixed  = neg_r_reg ? (~work_reg[2*DATA_W-1:DATA_W] + 1'b1)
                               : work_reg[2*DATA_W-1:DATA_W];
        if (is_div_reg) begin
            hi_out = rem_fixed;
            lo_out = quot_fixed;
        end else begin
            hi_out = prod_fixed[2*DATA_W-1:DATA_W];
            lo_out = prod_fixed[DATA_W-1:0];
        end
        done = (state_reg == ST_FIX);
    end

    // Sequencer: load, run the iterations, then correct signs.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        work_next   = work_reg;
        opnd_next   = opnd_reg;
        is_div_next = is_div_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next  = ST_RUN;
                    count_next  = '0;
                    is_div_next = op.is_div;
                    neg_q_next  = neg_a ^ neg_b;
                    neg_r_next  = neg_a;
                    if (op.is_div) begin
                        work_next = {{DATA_W{1'b0}}, mag_a};
                        opnd_next = mag_b;
                    end else begin
                        work_next = {{DATA_W{1'b0}}, mag_b};
                        opnd_next = mag_a;
                    end
                end
            end
            ST_RUN: begin
                work_next  = step_work;
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(ITERATIONS - 1)) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        work_reg   <= work_next;
        opnd_reg   <= opnd_next;
        is_div_reg <= is_div_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
    end

endmodule

[design/multiply_divide_unit_core.sv]
// ----------------------------------------------------------------------------
// Multiply/divide unit core
// HI/LO multiply, divide, move and read unit of a MIPS R3000 class processor.
// ----------------------------------------------------------------------------
// A move or read item is taken and its result item appears on the
// next cycle. A multiply or divide item occupies the unit through a load of
// the operand magnitudes, 32 iterations of the shared 34-bit adder (one
// multiplier or quotient bit each), and a sign-correction step; s_ready
// stays low meanwhile. Its result item (always zero) is issued at once, and a
// following read sees the finished HI/LO. A new item is taken while a result
// waits only if m_ready takes that result in the same cycle.
`timescale 1ns / 1ps

module multiply_divide_unit_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [mdu_pkg::CMD_W-1:0]  s_command,
    input  logic [mdu_pkg::DATA_W-1:0] s_operand_a,
    input  logic [mdu_pkg::DATA_W-1:0] s_operand_b,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [mdu_pkg::DATA_W-1:0] m_read_value
);
    import mdu_pkg::*;

    logic                busy_reg, busy_next;
    logic [DATA_W-1:0]   hi_reg, hi_next;
    logic [DATA_W-1:0]   lo_reg, lo_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;

    mdu_cmd_t            cmd;
    logic                accept;
    logic                alu_start;
    mdu_op_t             alu_op;
    logic                alu_done;
    logic [DATA_W-1:0]   alu_hi, alu_lo;

    // Input decode.
    always_comb begin
        cmd              = mdu_cmd_t'(s_command);
        s_ready          = !busy_reg && (!m_valid_reg || m_ready);
        accept           = s_valid && s_ready;
        alu_op.is_div    = (cmd == CMD_DIV) || (cmd == CMD_DIVU);
        alu_op.is_signed = (cmd == CMD_MULT) || (cmd == CMD_DIV);
        alu_start        = accept && (alu_op.is_div || cmd == CMD_MULT || cmd == CMD_MULTU);
    end

    mdu_alu u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (alu_start),
        .op        (alu_op),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .done      (alu_done),
        .hi_out    (alu_hi),
        .lo_out    (alu_lo)
    );

    // HI/LO update, busy tracking and the result register.
    always_comb begin
        busy_next    = busy_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (alu_done) begin
            busy_next = 1'b0;
            hi_next   = alu_hi;
            lo_next   = alu_lo;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            case (cmd)
                CMD_MULT, CMD_MULTU, CMD_DIV, CMD_DIVU: begin
                    busy_next = 1'b1;
                end
                CMD_WRITE_HI: begin
                    hi_next = s_operand_a;
                end
                CMD_WRITE_LO: begin
                    lo_next = s_operand_a;
                end
                CMD_READ_HI: begin
                    m_data_next = hi_reg;
                end
                CMD_READ_LO: begin
                    m_data_next = lo_reg;
                end
                default: begin
                    m_data_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            hi_reg      <= '0;
            lo_reg      <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            hi_reg      <= hi_next;
            lo_reg      <= lo_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_data_reg;

endmodule

[design/mdu_checker.sv]
// ----------------------------------------------------------------------------
// Multiply/divide unit checker
// Port-level assertions for the HI/LO unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multiply_divide_unit_core_defines.svh"

module mdu_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [mdu_pkg::CMD_W-1:0]  s_command,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [mdu_pkg::DATA_W-1:0] m_read_value
);
    import mdu_pkg::*;

    logic s_take;
    logic take_arith;
    logic take_silent;

    // Classes of accepted items.
    always_comb begin
        s_take      = s_valid && s_ready;
        take_arith  = s_take && (s_command == CMD_MULT || s_command == CMD_MULTU ||
                                 s_command == CMD_DIV || s_command == CMD_DIVU);
        take_silent = s_take && !(s_command == CMD_READ_HI || s_command == CMD_READ_LO);
    end

    // No result is pending right after reset.
    `MDU_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

    // A waiting result blocks new items.
    `MDU_ASSERT(a_no_overrun, (m_valid && !m_ready) |-> !s_ready, "item taken over a held result")

    // A multiply or divide keeps the unit busy on the following cycle.
    `MDU_ASSERT(a_arith_busy, take_arith |=> !s_ready, "ready during arithmetic")

    // Every item that is not a read yields a zero result.
    `MDU_ASSERT(a_silent_zero, take_silent |=> (m_valid && m_read_value == '0), "nonzero result")

    // A stalled result holds its value.
    `MDU_ASSERT(a_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_read_value)), "result changed")

endmodule

bind multiply_divide_unit_core mdu_checker u_mdu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_command    (s_command),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value)
);
